FILE: src/tpmp_pkg.sv
// Package for the three-point motion predictor: field widths, datapath widths,
// sequencer state type and the displacement clamp limit.
// No dependencies.
package tpmp_pkg;

  localparam int unsigned COORD_W   = 15;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned AIM_W     = 16;
  localparam int unsigned WIN_DEPTH = 3;
  localparam int unsigned FILL_W    = 2;

  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SUM_T_W = TIME_W + 1;
  localparam int unsigned SUM_S_W = TIME_W + 2;

  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = SUM_S_W;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

  localparam int unsigned PROD1_W = DIFF_W + TIME_W + 1;
  localparam int unsigned UW_W    = PROD1_W + 1;
  localparam int unsigned M3_W    = UW_W + SUM_T_W;
  localparam int unsigned M4_W    = UW_W + SUM_S_W;
  localparam int unsigned B_W     = 54;
  localparam int unsigned MAG_W   = B_W - 1;
  localparam int unsigned SPLIT   = 27;
  localparam int unsigned NLO_W   = SPLIT + SUM_S_W;
  localparam int unsigned NHI_W   = MAG_W - SPLIT + SUM_S_W;
  localparam int unsigned TT_W    = 2 * TIME_W;
  localparam int unsigned DP_W    = TT_W + SUM_T_W;

  localparam int unsigned DVD_W  = MAG_W + SUM_S_W;
  localparam int unsigned DVS_W  = DP_W + 5;
  localparam int unsigned QUO_W  = 41;
  localparam int unsigned DISP_W = QUO_W + 1;
  localparam int unsigned SUM_W  = DISP_W + 1;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);

  localparam logic [QUO_W-1:0] DISP_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TIME_W-1:0]  time_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TT,
    ST_DEN,
    ST_M1,
    ST_M2,
    ST_UW,
    ST_M3,
    ST_M4,
    ST_B,
    ST_ABS,
    ST_NLO,
    ST_NHI,
    ST_NUM,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

FILE: src/tpmp_if.sv
// Valid/ready channel interfaces for frame items and aim results.
// Depends on tpmp_pkg for field widths.
interface tpmp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [tpmp_pkg::COORD_W-1:0] target_x;
  logic [tpmp_pkg::COORD_W-1:0] target_y;
  logic [tpmp_pkg::TIME_W-1:0]  frame_interval;

  modport source(output valid, found, target_x, target_y, frame_interval, input ready);
  modport sink(input valid, found, target_x, target_y, frame_interval, output ready);
endinterface

interface tpmp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              aim_valid;
  logic signed [tpmp_pkg::AIM_W-1:0] aim_x;
  logic signed [tpmp_pkg::AIM_W-1:0] aim_y;
  logic                              predicted;

  modport source(output valid, aim_valid, aim_x, aim_y, predicted, input ready);
  modport sink(input valid, aim_valid, aim_x, aim_y, predicted, output ready);
endinterface

FILE: src/tpmp_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle, with
// round-half-up and a saturating quotient clamped at the displacement limit.
// Depends on tpmp_pkg.
module tpmp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tpmp_pkg::DVD_W-1:0]     dividend_i,
  input  logic [tpmp_pkg::DVS_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [tpmp_pkg::QUO_W-1:0]     quot_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [tpmp_pkg::CNT_W-1:0]   cnt_q;
  logic [tpmp_pkg::DVD_W-1:0]   dvd_q;
  logic [tpmp_pkg::DVS_W-1:0]   den_q;
  logic [tpmp_pkg::DVS_W-1:0]   rem_q;
  logic [tpmp_pkg::QUO_W-1:0]   q_q;
  logic                         over_q;
  logic [tpmp_pkg::QUO_W-1:0]   quot_q;

  logic [tpmp_pkg::DVS_W:0]     rem_sh;
  logic [tpmp_pkg::DVS_W:0]     rem_sub;
  logic                         ge;
  logic [tpmp_pkg::DVS_W-1:0]   rem_nx;
  logic                         rnd;
  logic                         sat;
  logic [tpmp_pkg::QUO_W-1:0]   quot_nx;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[tpmp_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_nx  = ge ? rem_sub[tpmp_pkg::DVS_W-1:0] : rem_sh[tpmp_pkg::DVS_W-1:0];
    rnd     = {rem_q, 1'b0} >= {1'b0, den_q};
    sat     = over_q | q_q[tpmp_pkg::QUO_W-1];
    quot_nx = sat ? tpmp_pkg::DISP_LIMIT : q_q + tpmp_pkg::QUO_W'(rnd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= tpmp_pkg::CNT_W'(tpmp_pkg::DVD_W);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      q_q    <= '0;
      over_q <= 1'b0;
    end else if (busy_q && (cnt_q != '0)) begin
      dvd_q  <= {dvd_q[tpmp_pkg::DVD_W-2:0], 1'b0};
      rem_q  <= rem_nx;
      q_q    <= {q_q[tpmp_pkg::QUO_W-2:0], ge};
      over_q <= over_q | q_q[tpmp_pkg::QUO_W-1];
    end else if (busy_q) begin
      quot_q <= quot_nx;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: src/three_point_motion_predictor_unit.sv
// Miss, filling hit and non-monotonic hit: the result goes from ST_OUT into the output
// register once the output is free. Predicting hit: the result comes from two runs of
// the 71-step shift-subtract divider (x, then y) and fourteen steps of the shared 36x18
// multiplier, then passes through ST_SUM and ST_OUT.
// One item at a time; the next transfer is taken the cycle after the result is queued,
// even while that result waits at the output. Reset empties the window and output.
module three_point_motion_predictor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpmp_in_if.sink     in_i,
  tpmp_out_if.source  out_o
);

  localparam logic signed [tpmp_pkg::SUM_W-1:0] SumMax =
    {{(tpmp_pkg::SUM_W-tpmp_pkg::AIM_W+1){1'b0}}, {(tpmp_pkg::AIM_W-1){1'b1}}};
  localparam logic signed [tpmp_pkg::SUM_W-1:0] SumMin =
    {{(tpmp_pkg::SUM_W-tpmp_pkg::AIM_W+1){1'b1}}, {(tpmp_pkg::AIM_W-1){1'b0}}};

  function automatic logic signed [tpmp_pkg::AIM_W-1:0] sat_aim(
    input logic signed [tpmp_pkg::SUM_W-1:0] v
  );
    priority if (v > SumMax) begin
      return {1'b0, {(tpmp_pkg::AIM_W-1){1'b1}}};
    end else if (v < SumMin) begin
      return {1'b1, {(tpmp_pkg::AIM_W-1){1'b0}}};
    end else begin
      return v[tpmp_pkg::AIM_W-1:0];
    end
  endfunction

  tpmp_pkg::state_e state_q, state_d;

  logic [tpmp_pkg::FILL_W-1:0]  fill_q;
  logic                         tracking_q;
  logic                         coord_q;
  tpmp_pkg::coord_t             win_x_q [tpmp_pkg::WIN_DEPTH];
  tpmp_pkg::coord_t             win_y_q [tpmp_pkg::WIN_DEPTH];
  tpmp_pkg::time_t              win_t_q [tpmp_pkg::WIN_DEPTH];
  logic [tpmp_pkg::SUM_T_W-1:0] t12_q;
  logic [tpmp_pkg::SUM_S_W-1:0] s_q;

  logic [tpmp_pkg::TT_W-1:0]            tt_q;
  logic [tpmp_pkg::DP_W-1:0]            dp_q;
  logic signed [tpmp_pkg::PROD1_W-1:0]  m1_q, m2_q;
  logic signed [tpmp_pkg::UW_W-1:0]     u_q, w_q;
  logic signed [tpmp_pkg::M3_W-1:0]     m3_q;
  logic signed [tpmp_pkg::M4_W-1:0]     m4_q;
  logic signed [tpmp_pkg::B_W-1:0]      b_q;
  logic [tpmp_pkg::MAG_W-1:0]           mag_q;
  logic                                 neg_q;
  logic [tpmp_pkg::NLO_W-1:0]           nlo_q;
  logic [tpmp_pkg::NHI_W-1:0]           nhi_q;
  logic signed [tpmp_pkg::DISP_W-1:0]   disp_x_q, disp_y_q;

  logic                               res_valid_q, res_pred_q;
  logic signed [tpmp_pkg::AIM_W-1:0]  res_x_q, res_y_q;
  logic                               out_valid_q, out_aim_valid_q, out_pred_q;
  logic signed [tpmp_pkg::AIM_W-1:0]  out_x_q, out_y_q;

  logic                                 accept;
  logic                                 out_load;
  tpmp_pkg::time_t                      dt_fix;
  logic                                 mono;
  tpmp_pkg::coord_t                     c0, c1, c2;
  logic signed [tpmp_pkg::DIFF_W-1:0]   d1, d2;
  logic signed [tpmp_pkg::MUL_A_W-1:0]  mul_a;
  logic [tpmp_pkg::MUL_B_W-1:0]         mul_b;
  logic signed [tpmp_pkg::MUL_P_W-1:0]  prod;
  logic signed [tpmp_pkg::B_W-1:0]      m3_ext, m4_ext, b_neg;
  logic signed [tpmp_pkg::DISP_W-1:0]   quot_ext, disp_nx;
  logic signed [tpmp_pkg::SUM_W-1:0]    sum_x, sum_y;
  logic signed [tpmp_pkg::AIM_W-1:0]    sat_x, sat_y;

  logic                          div_start;
  logic                          div_done;
  logic [tpmp_pkg::DVD_W-1:0]    div_dividend;
  logic [tpmp_pkg::DVS_W-1:0]    div_divisor;
  logic [tpmp_pkg::QUO_W-1:0]    div_quot;

  tpmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign accept   = in_i.valid && in_i.ready;
  assign out_load = (state_q == tpmp_pkg::ST_OUT) && (!out_valid_q || out_o.ready);
  assign dt_fix   = (in_i.frame_interval == '0) ? tpmp_pkg::TIME_W'(1) : in_i.frame_interval;
  assign mono     = ((win_x_q[1] < win_x_q[2]) && (win_x_q[2] < in_i.target_x)) ||
                    ((win_x_q[1] > win_x_q[2]) && (win_x_q[2] > in_i.target_x));

  always_comb begin
    c0 = coord_q ? win_y_q[0] : win_x_q[0];
    c1 = coord_q ? win_y_q[1] : win_x_q[1];
    c2 = coord_q ? win_y_q[2] : win_x_q[2];
    d1 = $signed({1'b0, c1}) - $signed({1'b0, c0});
    d2 = $signed({1'b0, c2}) - $signed({1'b0, c1});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      tpmp_pkg::ST_TT: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::TIME_W){1'b0}}, win_t_q[1]};
        mul_b = {{(tpmp_pkg::MUL_B_W-tpmp_pkg::TIME_W){1'b0}}, win_t_q[2]};
      end
      tpmp_pkg::ST_DEN: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::TT_W){1'b0}}, tt_q};
        mul_b = {{(tpmp_pkg::MUL_B_W-tpmp_pkg::SUM_T_W){1'b0}}, t12_q};
      end
      tpmp_pkg::ST_M1: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::DIFF_W){d1[tpmp_pkg::DIFF_W-1]}}, d1};
        mul_b = {{(tpmp_pkg::MUL_B_W-tpmp_pkg::TIME_W){1'b0}}, win_t_q[2]};
      end
      tpmp_pkg::ST_M2: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::DIFF_W){d2[tpmp_pkg::DIFF_W-1]}}, d2};
        mul_b = {{(tpmp_pkg::MUL_B_W-tpmp_pkg::TIME_W){1'b0}}, win_t_q[1]};
      end
      tpmp_pkg::ST_M3: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::UW_W){u_q[tpmp_pkg::UW_W-1]}}, u_q};
        mul_b = {{(tpmp_pkg::MUL_B_W-tpmp_pkg::SUM_T_W){1'b0}}, t12_q};
      end
      tpmp_pkg::ST_M4: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::UW_W){w_q[tpmp_pkg::UW_W-1]}}, w_q};
        mul_b = s_q;
      end
      tpmp_pkg::ST_NLO: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-tpmp_pkg::SPLIT){1'b0}}, mag_q[tpmp_pkg::SPLIT-1:0]};
        mul_b = s_q;
      end
      tpmp_pkg::ST_NHI: begin
        mul_a = {{(tpmp_pkg::MUL_A_W-(tpmp_pkg::MAG_W-tpmp_pkg::SPLIT)){1'b0}},
                 mag_q[tpmp_pkg::MAG_W-1:tpmp_pkg::SPLIT]};
        mul_b = s_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  always_comb begin
    m3_ext   = {{(tpmp_pkg::B_W-tpmp_pkg::M3_W){m3_q[tpmp_pkg::M3_W-1]}}, m3_q};
    m4_ext   = {{(tpmp_pkg::B_W-tpmp_pkg::M4_W){m4_q[tpmp_pkg::M4_W-1]}}, m4_q};
    b_neg    = -b_q;
    quot_ext = {1'b0, div_quot};
    disp_nx  = neg_q ? -quot_ext : quot_ext;
    div_dividend = {nhi_q, {tpmp_pkg::SPLIT{1'b0}}} + tpmp_pkg::DVD_W'(nlo_q);
    div_divisor  = (tpmp_pkg::DVS_W'(dp_q) << 4) + (tpmp_pkg::DVS_W'(dp_q) << 1);
    sum_x = $signed({{(tpmp_pkg::SUM_W-tpmp_pkg::DISP_W){disp_x_q[tpmp_pkg::DISP_W-1]}},
                     disp_x_q}) +
            $signed({{(tpmp_pkg::SUM_W-tpmp_pkg::COORD_W){1'b0}}, win_x_q[2]});
    sum_y = $signed({{(tpmp_pkg::SUM_W-tpmp_pkg::DISP_W){disp_y_q[tpmp_pkg::DISP_W-1]}},
                     disp_y_q}) +
            $signed({{(tpmp_pkg::SUM_W-tpmp_pkg::COORD_W){1'b0}}, win_y_q[2]});
    sat_x = sat_aim(sum_x);
    sat_y = sat_aim(sum_y);
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      tpmp_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (!in_i.found || !tracking_q || !mono) begin
            state_d = tpmp_pkg::ST_OUT;
          end else begin
            state_d = tpmp_pkg::ST_TT;
          end
        end
      end
      tpmp_pkg::ST_TT:  state_d = tpmp_pkg::ST_DEN;
      tpmp_pkg::ST_DEN: state_d = tpmp_pkg::ST_M1;
      tpmp_pkg::ST_M1:  state_d = tpmp_pkg::ST_M2;
      tpmp_pkg::ST_M2:  state_d = tpmp_pkg::ST_UW;
      tpmp_pkg::ST_UW:  state_d = tpmp_pkg::ST_M3;
      tpmp_pkg::ST_M3:  state_d = tpmp_pkg::ST_M4;
      tpmp_pkg::ST_M4:  state_d = tpmp_pkg::ST_B;
      tpmp_pkg::ST_B:   state_d = tpmp_pkg::ST_ABS;
      tpmp_pkg::ST_ABS: state_d = tpmp_pkg::ST_NLO;
      tpmp_pkg::ST_NLO: state_d = tpmp_pkg::ST_NHI;
      tpmp_pkg::ST_NHI: state_d = tpmp_pkg::ST_NUM;
      tpmp_pkg::ST_NUM: begin
        div_start = 1'b1;
        state_d   = tpmp_pkg::ST_DIV;
      end
      tpmp_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = coord_q ? tpmp_pkg::ST_SUM : tpmp_pkg::ST_M1;
        end
      end
      tpmp_pkg::ST_SUM: state_d = tpmp_pkg::ST_OUT;
      tpmp_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = tpmp_pkg::ST_IDLE;
        end
      end
      default: state_d = tpmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      tracking_q  <= 1'b0;
      coord_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        coord_q <= 1'b0;
        if (!in_i.found) begin
          fill_q     <= '0;
          tracking_q <= 1'b0;
        end else if (!tracking_q) begin
          fill_q     <= fill_q + 1'b1;
          tracking_q <= (fill_q == tpmp_pkg::FILL_W'(tpmp_pkg::WIN_DEPTH - 1));
        end
      end else if ((state_q == tpmp_pkg::ST_DIV) && div_done) begin
        coord_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_valid_q <= 1'b0;
      res_pred_q  <= 1'b0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      if (in_i.found && !tracking_q) begin
        win_x_q[fill_q] <= in_i.target_x;
        win_y_q[fill_q] <= in_i.target_y;
        win_t_q[fill_q] <= dt_fix;
        res_valid_q     <= 1'b1;
        res_x_q         <= {1'b0, in_i.target_x};
        res_y_q         <= {1'b0, in_i.target_y};
      end else if (in_i.found) begin
        win_x_q[0] <= win_x_q[1];
        win_x_q[1] <= win_x_q[2];
        win_x_q[2] <= in_i.target_x;
        win_y_q[0] <= win_y_q[1];
        win_y_q[1] <= win_y_q[2];
        win_y_q[2] <= in_i.target_y;
        win_t_q[0] <= win_t_q[1];
        win_t_q[1] <= win_t_q[2];
        win_t_q[2] <= dt_fix;
        t12_q      <= {1'b0, win_t_q[2]} + {1'b0, dt_fix};
        s_q        <= {2'b00, win_t_q[1]} + {2'b00, win_t_q[2]} + {2'b00, dt_fix};
      end
    end
    unique case (state_q)
      tpmp_pkg::ST_TT:  tt_q  <= prod[tpmp_pkg::TT_W-1:0];
      tpmp_pkg::ST_DEN: dp_q  <= prod[tpmp_pkg::DP_W-1:0];
      tpmp_pkg::ST_M1:  m1_q  <= prod[tpmp_pkg::PROD1_W-1:0];
      tpmp_pkg::ST_M2:  m2_q  <= prod[tpmp_pkg::PROD1_W-1:0];
      tpmp_pkg::ST_UW: begin
        u_q <= $signed({m1_q[tpmp_pkg::PROD1_W-1], m1_q}) +
               $signed({m2_q[tpmp_pkg::PROD1_W-1], m2_q});
        w_q <= $signed({m2_q[tpmp_pkg::PROD1_W-1], m2_q}) -
               $signed({m1_q[tpmp_pkg::PROD1_W-1], m1_q});
      end
      tpmp_pkg::ST_M3:  m3_q  <= prod[tpmp_pkg::M3_W-1:0];
      tpmp_pkg::ST_M4:  m4_q  <= prod[tpmp_pkg::M4_W-1:0];
      tpmp_pkg::ST_B:   b_q   <= (m3_ext <<< 1) + m3_ext + (m4_ext <<< 1);
      tpmp_pkg::ST_ABS: begin
        neg_q <= b_q[tpmp_pkg::B_W-1];
        mag_q <= b_q[tpmp_pkg::B_W-1] ? b_neg[tpmp_pkg::MAG_W-1:0]
                                      : b_q[tpmp_pkg::MAG_W-1:0];
      end
      tpmp_pkg::ST_NLO: nlo_q <= prod[tpmp_pkg::NLO_W-1:0];
      tpmp_pkg::ST_NHI: nhi_q <= prod[tpmp_pkg::NHI_W-1:0];
      tpmp_pkg::ST_DIV: begin
        if (div_done) begin
          if (coord_q) begin
            disp_y_q <= disp_nx;
          end else begin
            disp_x_q <= disp_nx;
          end
        end
      end
      tpmp_pkg::ST_SUM: begin
        res_x_q     <= sat_x;
        res_y_q     <= sat_y;
        res_valid_q <= !sat_x[tpmp_pkg::AIM_W-1] && !sat_y[tpmp_pkg::AIM_W-1];
        res_pred_q  <= 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_aim_valid_q <= res_valid_q;
      out_x_q         <= res_x_q;
      out_y_q         <= res_y_q;
      out_pred_q      <= res_pred_q;
    end
  end

  assign in_i.ready      = (state_q == tpmp_pkg::ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.aim_valid = out_aim_valid_q;
  assign out_o.aim_x     = out_x_q;
  assign out_o.aim_y     = out_y_q;
  assign out_o.predicted = out_pred_q;

  a_track_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tracking_q == (fill_q == tpmp_pkg::FILL_W'(tpmp_pkg::WIN_DEPTH)))
    else $error("tracking flag out of step with fill count");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tpmp_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == tpmp_pkg::ST_IDLE)))
    else $error("result not presented after load");

  a_aim_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.aim_valid) |-> (!out_o.aim_x[tpmp_pkg::AIM_W-1] &&
                                          !out_o.aim_y[tpmp_pkg::AIM_W-1]))
    else $error("aim flagged valid with a negative coordinate");

endmodule
